// ===== rtl/core/overwriting_ring_queue_with_cursor_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Overwriting ring queue assertion macros
// Shared concurrent assertion forms for the ring queue modules.
// ----------------------------------------------------------------------------
`ifndef OVERWRITING_RING_QUEUE_WITH_CURSOR_UNIT_ASSERT_SVH
`define OVERWRITING_RING_QUEUE_WITH_CURSOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define ORQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ORQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/orq_pkg.sv =====
// ----------------------------------------------------------------------------
// Ring queue package
// Operation codes, field widths and the word types shared by the queue files.
// ----------------------------------------------------------------------------
package orq_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int CAP_W  = 5;

  localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 3'd1;
  localparam logic [OP_W-1:0] OP_PREV    = 3'd2;
  localparam logic [OP_W-1:0] OP_NEXT    = 3'd3;
  localparam logic [OP_W-1:0] OP_CURRENT = 3'd4;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              data_valid;
    logic              is_empty;
    logic              is_full;
  } rsp_t;

  // Result status carried from the control block to the output stage.
  typedef struct packed {
    logic data_valid;
    logic is_empty;
    logic is_full;
  } status_t;

endpackage

// ===== rtl/core/orq_ram.sv =====
// ----------------------------------------------------------------------------
// Ring queue slot RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module orq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/orq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Ring queue control
// Front, rear, cursor and count registers, capacity register, the clearing
// sweep after reset, and the RAM addressing for each command.
// ----------------------------------------------------------------------------
`include "overwriting_ring_queue_with_cursor_unit_assert.svh"

module orq_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [orq_pkg::OP_W-1:0]             op,
  input  logic                                 cfg_we,
  input  logic [orq_pkg::CAP_W-1:0]            cfg_data,
  output logic                                 busy,
  output logic                                 mem_we,
  output logic                                 mem_clr,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] mem_waddr,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] mem_raddr,
  output logic                                 done,
  output orq_pkg::status_t                     status
);

  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_W   = orq_pkg::CAP_W;
  localparam int CMP_W   = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;
  localparam int DCLAMP  = (DEPTH > 31) ? 31 : DEPTH;
  localparam logic [CAP_W-1:0] DEPTH_CAP = CAP_W'(DCLAMP);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);

  logic [IDX_W-1:0] front, front_next;
  logic [IDX_W-1:0] rear, rear_next;
  logic [IDX_W-1:0] cursor, cursor_next;
  logic [CAP_W-1:0] count, count_next;
  logic [CAP_W-1:0] cap;
  logic             clr_active;
  logic [IDX_W-1:0] clr_addr;
  orq_pkg::status_t status_next;

  logic [CAP_W-1:0] eff_cap;
  logic             accept;
  logic [IDX_W-1:0] rd_idx;

  function automatic logic [IDX_W-1:0] step_fwd(input logic [IDX_W-1:0] i,
                                                input logic [CAP_W-1:0] c);
    logic [CMP_W-1:0] inc;
    inc = CMP_W'(i) + CMP_W'(1);
    step_fwd = (inc >= CMP_W'(c)) ? '0 : inc[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] i,
                                                 input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] top;
    top = c - CAP_W'(1);
    step_back = (i == '0) ? IDX_W'(top) : i - IDX_W'(1);
  endfunction

  // Zero acts as one, anything past the store depth acts as the depth.
  assign eff_cap = (cap == '0) ? CAP_W'(1) : ((cap > DEPTH_CAP) ? DEPTH_CAP : cap);
  assign accept  = start & ~clr_active;
  assign busy    = clr_active;

  always_comb begin
    front_next  = front;
    rear_next   = rear;
    cursor_next = cursor;
    count_next  = count;
    rd_idx      = cursor;
    mem_we      = 1'b0;
    status_next.data_valid = 1'b0;
    if (accept) begin
      case (op)
        orq_pkg::OP_ENQUEUE: begin
          mem_we = 1'b1;
          if (count >= eff_cap) begin
            front_next = step_fwd(front, eff_cap);
          end else begin
            count_next = count + CAP_W'(1);
          end
          rear_next   = step_fwd(rear, eff_cap);
          cursor_next = rear_next;
        end
        orq_pkg::OP_DEQUEUE: begin
          rd_idx = front;
          if (count != '0) begin
            status_next.data_valid = 1'b1;
            front_next = step_fwd(front, eff_cap);
            count_next = count - CAP_W'(1);
          end
        end
        orq_pkg::OP_PREV: begin
          if (cursor != front) begin
            cursor_next = step_back(cursor, eff_cap);
            rd_idx      = cursor_next;
            status_next.data_valid = 1'b1;
          end
        end
        orq_pkg::OP_NEXT: begin
          if (cursor != rear) begin
            cursor_next = step_fwd(cursor, eff_cap);
            rd_idx      = cursor_next;
            status_next.data_valid = 1'b1;
          end
        end
        orq_pkg::OP_CURRENT: begin
          status_next.data_valid = 1'b1;
        end
        default: begin
        end
      endcase
    end
    status_next.is_empty = (count_next == '0);
    status_next.is_full  = (count_next == eff_cap);
  end

  // The sweep owns the write port until the store is zeroed.
  assign mem_clr   = clr_active;
  assign mem_waddr = clr_active ? clr_addr : rear;
  assign mem_raddr = rd_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      front      <= '0;
      rear       <= '0;
      cursor     <= '0;
      count      <= '0;
      cap        <= orq_pkg::CAP_RESET;
      clr_active <= 1'b1;
      clr_addr   <= '0;
      done       <= 1'b0;
    end else begin
      if (clr_active) begin
        clr_addr <= clr_addr + IDX_W'(1);
        if (clr_addr == LAST_IDX) begin
          clr_active <= 1'b0;
        end
      end
      if (cfg_we) begin
        cap    <= cfg_data;
        front  <= '0;
        rear   <= '0;
        cursor <= '0;
        count  <= '0;
      end else begin
        front  <= front_next;
        rear   <= rear_next;
        cursor <= cursor_next;
        count  <= count_next;
      end
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
    end
  end

  `ORQ_ASSERT_IMP(a_count_in_cap, clk, rst, 1'b1, count <= eff_cap, "count exceeds capacity")
  `ORQ_ASSERT_IMP(a_idx_in_cap, clk, rst, 1'b1,
    (CMP_W'(front) < CMP_W'(eff_cap)) && (CMP_W'(rear) < CMP_W'(eff_cap)) &&
    (CMP_W'(cursor) < CMP_W'(eff_cap)), "index outside ring")
  `ORQ_ASSERT_NEXT(a_done_after_accept, clk, rst, accept, done, "missing result strobe")
  `ORQ_ASSERT_NEXT(a_no_spurious_done, clk, rst, !accept, !done, "result without command")
  `ORQ_ASSERT_IMP(a_no_done_in_clear, clk, rst, clr_active, !done, "result during clear")

endmodule

// ===== rtl/core/overwriting_ring_queue_with_cursor_unit.sv =====
// ----------------------------------------------------------------------------
// Overwriting ring queue with browsing cursor
// Ring of words that overwrites its oldest entry when full, with a cursor
// that steps through the entries toward the front or the rear.
//
//   channel   signals                     direction  handshake
//   command   start, busy, req            in         start & !busy
//   result    done, rsp                   out        done, one cycle
//   config    cfg_valid, cfg_ready, cfg_data  in     cfg_valid & cfg_ready
//
// One command per cycle while busy is low; its result shows in the cycle after
// acceptance, set by the registered read port of the slot RAM.
// After reset the store is zeroed by a sweep over every slot with busy high;
// configuration writes are still taken then.
// The result strobe cannot be held off; cfg_ready is always high.
// ----------------------------------------------------------------------------
module overwriting_ring_queue_with_cursor_unit #(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  orq_pkg::req_t                 req,
  output logic                          done,
  output orq_pkg::rsp_t                 rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [orq_pkg::CAP_W-1:0]     cfg_data
);

  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W = orq_pkg::DATA_W;

  logic                  mem_we;
  logic                  mem_clr;
  logic [IDX_W-1:0]      mem_waddr;
  logic [IDX_W-1:0]      mem_raddr;
  logic [ITEM_WIDTH-1:0] mem_wdata;
  logic [ITEM_WIDTH-1:0] mem_rdata;
  logic [ITEM_WIDTH-1:0] item_in;
  logic [DATA_W-1:0]     word_out;
  orq_pkg::status_t      status;

  assign cfg_ready = 1'b1;

  // Fit the port word to the slot width both ways.
  generate
    if (ITEM_WIDTH >= DATA_W) begin : g_wide
      assign item_in  = ITEM_WIDTH'(req.data_in);
      assign word_out = mem_rdata[DATA_W-1:0];
    end else begin : g_narrow
      assign item_in  = req.data_in[ITEM_WIDTH-1:0];
      assign word_out = DATA_W'(mem_rdata);
    end
  endgenerate

  assign mem_wdata = mem_clr ? '0 : item_in;

  orq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .op        (req.op),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .mem_we    (mem_we),
    .mem_clr   (mem_clr),
    .mem_waddr (mem_waddr),
    .mem_raddr (mem_raddr),
    .done      (done),
    .status    (status)
  );

  orq_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we | mem_clr),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    rsp.data_out   = status.data_valid ? word_out : '0;
    rsp.data_valid = status.data_valid;
    rsp.is_empty   = status.is_empty;
    rsp.is_full    = status.is_full;
  end

endmodule

// ===== tb/overwriting_ring_queue_with_cursor_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Ring queue with browsing cursor testbench
// Drives enqueue, dequeue, cursor and unknown commands under a range of
// capacity settings, with random gaps on the command side. Every result word
// is checked field by field against a predicted ring state.
// ----------------------------------------------------------------------------
module overwriting_ring_queue_with_cursor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = 16;
  localparam int TARGET_CMDS = 2000;
  localparam int DATA_W      = orq_pkg::DATA_W;
  localparam int OP_W        = orq_pkg::OP_W;
  localparam int CAP_W       = orq_pkg::CAP_W;

  class ring_queue_tracker;
    logic [DATA_W-1:0] slots [SLOTS];
    int unsigned       front;
    int unsigned       rear;
    int unsigned       cursor;
    int unsigned       count;
    logic [CAP_W-1:0]  cap_reg;
    orq_pkg::rsp_t     expected_q [$];
    int unsigned       errors;
    int unsigned       n_cmds;
    int unsigned       n_words;
    int unsigned       n_returned;

    function new();
      foreach (slots[i]) slots[i] = '0;
      front      = 0;
      rear       = 0;
      cursor     = 0;
      count      = 0;
      cap_reg    = orq_pkg::CAP_RESET;
      errors     = 0;
      n_cmds     = 0;
      n_words    = 0;
      n_returned = 0;
    endfunction

    function int unsigned live_cap();
      if (cap_reg == 0) return 1;
      if (cap_reg > SLOTS) return SLOTS;
      return cap_reg;
    endfunction

    function int unsigned advance(int unsigned i, int unsigned c);
      return (i + 1 >= c) ? 0 : i + 1;
    endfunction

    function int unsigned retreat(int unsigned i, int unsigned c);
      return (i == 0) ? c - 1 : i - 1;
    endfunction

    // Capacity write empties the queue but leaves the slots alone.
    function void load_capacity(logic [CAP_W-1:0] v);
      cap_reg = v;
      front   = 0;
      rear    = 0;
      cursor  = 0;
      count   = 0;
    endfunction

    function orq_pkg::rsp_t step_ring(orq_pkg::req_t r);
      orq_pkg::rsp_t o;
      int unsigned   c;
      c = live_cap();
      o = '0;
      case (r.op)
        orq_pkg::OP_ENQUEUE: begin
          slots[rear] = r.data_in;
          if (count >= c) front = advance(front, c);
          else count++;
          rear   = advance(rear, c);
          cursor = rear;
        end
        orq_pkg::OP_DEQUEUE: begin
          if (count != 0) begin
            o.data_out   = slots[front];
            o.data_valid = 1'b1;
            front        = advance(front, c);
            count--;
          end
        end
        orq_pkg::OP_PREV: begin
          if (cursor != front) begin
            cursor       = retreat(cursor, c);
            o.data_out   = slots[cursor];
            o.data_valid = 1'b1;
          end
        end
        orq_pkg::OP_NEXT: begin
          if (cursor != rear) begin
            cursor       = advance(cursor, c);
            o.data_out   = slots[cursor];
            o.data_valid = 1'b1;
          end
        end
        orq_pkg::OP_CURRENT: begin
          o.data_out   = slots[cursor];
          o.data_valid = 1'b1;
        end
        default: ;
      endcase
      o.is_empty = (count == 0);
      o.is_full  = (count == c);
      return o;
    endfunction

    function void note_cmd(orq_pkg::req_t r);
      orq_pkg::rsp_t o;
      o = step_ring(r);
      if (o.data_valid) n_returned++;
      expected_q.push_back(o);
      n_cmds++;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void check_rsp(orq_pkg::rsp_t got);
      orq_pkg::rsp_t want;
      n_words++;
      if (expected_q.size() == 0) begin
        flag($sformatf("result word with nothing pending: %p", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.data_out !== want.data_out)
        flag($sformatf("data_out exp %h got %h", want.data_out, got.data_out));
      if (got.data_valid !== want.data_valid)
        flag($sformatf("data_valid exp %b got %b", want.data_valid, got.data_valid));
      if (got.is_empty !== want.is_empty)
        flag($sformatf("is_empty exp %b got %b", want.is_empty, got.is_empty));
      if (got.is_full !== want.is_full)
        flag($sformatf("is_full exp %b got %b", want.is_full, got.is_full));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  orq_pkg::req_t    req;
  logic             done;
  orq_pkg::rsp_t    rsp;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data;

  ring_queue_tracker board;
  bit                gaps_on;
  int unsigned       n_cfg;

  overwriting_ring_queue_with_cursor_unit #(
    .DEPTH(SLOTS),
    .ITEM_WIDTH(DATA_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_rsp(rsp);
  end

  function automatic orq_pkg::req_t mk(logic [OP_W-1:0] op, logic [DATA_W-1:0] d);
    orq_pkg::req_t r;
    r.op      = op;
    r.data_in = d;
    return r;
  endfunction

  task automatic send_cmd(input orq_pkg::req_t r);
    while (gaps_on && $urandom_range(0, 99) < 32) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_cmd(r);
  endtask

  // Drain every pending word before touching the register.
  task automatic write_capacity(input logic [CAP_W-1:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.load_capacity(v);
    n_cfg++;
  endtask

  function automatic orq_pkg::req_t random_cmd(int unsigned enq_weight);
    logic [DATA_W-1:0] d;
    int unsigned       k;
    case ($urandom_range(0, 9))
      0:       d = '0;
      1:       d = '1;
      default: d = $urandom;
    endcase
    if ($urandom_range(0, 99) < enq_weight) return mk(orq_pkg::OP_ENQUEUE, d);
    k = $urandom_range(0, 99);
    if (k < 22) return mk(orq_pkg::OP_DEQUEUE, d);
    if (k < 46) return mk(orq_pkg::OP_PREV, d);
    if (k < 70) return mk(orq_pkg::OP_NEXT, d);
    if (k < 90) return mk(orq_pkg::OP_CURRENT, d);
    return mk(orq_pkg::OP_CURRENT + OP_W'($urandom_range(1, 3)), d);
  endfunction

  initial begin
    logic [CAP_W-1:0] caps [$];
    int unsigned      phase;
    int unsigned      len;
    int unsigned      enq_w;

    board     = new();
    n_cfg     = 0;
    gaps_on   = 1'b1;
    rst       = 1'b1;
    start     = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset capacity: empty-queue corners, then fill and browse both ways.
    send_cmd(mk(orq_pkg::OP_CURRENT, '0));
    send_cmd(mk(orq_pkg::OP_DEQUEUE, '0));
    send_cmd(mk(orq_pkg::OP_PREV, '0));
    send_cmd(mk(orq_pkg::OP_NEXT, '0));
    send_cmd(mk(orq_pkg::OP_CURRENT + 3'd1, 32'h1234_5678));
    send_cmd(mk(orq_pkg::OP_CURRENT + 3'd3, '1));
    send_cmd(mk(orq_pkg::OP_ENQUEUE, '0));
    send_cmd(mk(orq_pkg::OP_ENQUEUE, '1));
    send_cmd(mk(orq_pkg::OP_ENQUEUE, 32'hA5A5_A5A5));
    send_cmd(mk(orq_pkg::OP_PREV, '0));
    send_cmd(mk(orq_pkg::OP_PREV, '0));
    send_cmd(mk(orq_pkg::OP_PREV, '0));
    send_cmd(mk(orq_pkg::OP_NEXT, '0));
    send_cmd(mk(orq_pkg::OP_NEXT, '0));
    send_cmd(mk(orq_pkg::OP_NEXT, '0));
    send_cmd(mk(orq_pkg::OP_CURRENT, '0));
    send_cmd(mk(orq_pkg::OP_DEQUEUE, '0));
    send_cmd(mk(orq_pkg::OP_DEQUEUE, '0));
    send_cmd(mk(orq_pkg::OP_DEQUEUE, '0));
    send_cmd(mk(orq_pkg::OP_DEQUEUE, '0));

    // Single slot: second enqueue overwrites, cursor pinned at the front.
    write_capacity(5'd1);
    send_cmd(mk(orq_pkg::OP_ENQUEUE, 32'h0000_0001));
    send_cmd(mk(orq_pkg::OP_ENQUEUE, 32'h8000_0000));
    send_cmd(mk(orq_pkg::OP_PREV, '0));
    send_cmd(mk(orq_pkg::OP_NEXT, '0));
    send_cmd(mk(orq_pkg::OP_CURRENT, '0));

    caps  = '{5'd0, 5'd31, 5'd2, 5'd16, 5'd17, 5'd3, 5'd1, 5'd15};
    phase = 0;
    while (board.n_cmds < TARGET_CMDS) begin
      if (phase < caps.size()) write_capacity(caps[phase]);
      else write_capacity(CAP_W'($urandom_range(0, 31)));
      gaps_on = (phase != 3);
      enq_w   = $urandom_range(20, 60);
      len     = $urandom_range(120, 210);
      repeat (len) send_cmd(random_cmd(enq_w));
      phase++;
    end
    gaps_on = 1'b1;
    start <= 1'b0;

    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("ran %0d commands over %0d capacity settings, %0d result words checked",
             board.n_cmds, n_cfg, board.n_words);
    $display("%0d words returned valid, %0d mismatches", board.n_returned, board.errors);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("overwriting_ring_queue_with_cursor_unit_tb OK");
    end else begin
      $display("overwriting_ring_queue_with_cursor_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout");
    $display("overwriting_ring_queue_with_cursor_unit_tb NOT OK");
    $finish;
  end

endmodule
